### rtl/rbsi_pkg.sv
// Shared types and constants for the 2D ray versus box slab test.
`default_nettype none
package rbsi_pkg;

  localparam int TimeW   = 32;
  localparam int NumW    = 34;
  localparam int DivSteps = 32;
  localparam int DivLat  = DivSteps + 2;

  localparam logic signed [TimeW-1:0] TMax = 32'sh7FFF_FFFF;
  localparam logic signed [TimeW-1:0] TMin = 32'sh8000_0000;

  localparam logic signed [1:0] NormPos  = 2'sb01;
  localparam logic signed [1:0] NormNeg  = 2'sb11;
  localparam logic signed [1:0] NormZero = 2'sb00;

  // Ray data carried alongside the face times.
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } side_t;

  // Slab stage result toward the contact stages.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] tn;
    logic signed [1:0]  nx;
    logic signed [1:0]  ny;
    side_t              side;
  } slab_t;

endpackage
`default_nettype wire

### rtl/rbsi_div.sv
// Pipelined signed face-time divider, one quotient bit per stage, saturating.
`default_nettype none
module rbsi_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_vld,
  input  wire logic signed [rbsi_pkg::NumW-1:0]      num,
  input  wire logic signed [rbsi_pkg::TimeW-1:0]     dir,
  output logic                                       out_vld,
  output logic signed [rbsi_pkg::TimeW-1:0]          t,
  output logic                                       nan
);

  localparam int S = rbsi_pkg::DivSteps;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] d;
    logic [31:0] q;
    logic [31:0] low;
    logic        ovf;
    logic        neg;
    logic        zd;
    logic        nz;
    logic        npos;
  } dst_t;

  dst_t st [0:S];
  logic vld [0:S];

  logic [rbsi_pkg::NumW-1:0] mag;
  logic [31:0]               dmag;
  dst_t                      st0;

  always_comb begin
    mag      = num[rbsi_pkg::NumW-1] ? 34'(-num) : 34'(num);
    dmag     = dir[31] ? 32'(-dir) : 32'(dir);
    st0.r    = {15'd0, mag[32:16]};
    st0.d    = dmag;
    st0.q    = '0;
    st0.low  = {mag[15:0], 16'd0};
    st0.ovf  = {15'd0, mag[32:16]} >= dmag;
    st0.neg  = num[rbsi_pkg::NumW-1] ^ dir[31];
    st0.zd   = (dir == '0);
    st0.nz   = (num == '0);
    st0.npos = !num[rbsi_pkg::NumW-1] && (num != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      st[0] <= st0;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_step
    logic [32:0] r2;
    logic        ge;
    dst_t        nxt;
    always_comb begin
      r2      = {st[i].r, st[i].low[31]};
      ge      = r2 >= {1'b0, st[i].d};
      nxt     = st[i];
      nxt.r   = ge ? 32'(r2 - {1'b0, st[i].d}) : r2[31:0];
      nxt.q   = {st[i].q[30:0], ge};
      nxt.low = {st[i].low[30:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  logic signed [31:0] t_next;
  logic               nan_next;

  always_comb begin
    nan_next = 1'b0;
    if (st[S].zd) begin
      nan_next = st[S].nz;
      t_next   = st[S].npos ? rbsi_pkg::TMax : rbsi_pkg::TMin;
    end else if (st[S].ovf) begin
      t_next = st[S].neg ? rbsi_pkg::TMin : rbsi_pkg::TMax;
    end else if (!st[S].neg) begin
      t_next = st[S].q[31] ? rbsi_pkg::TMax : $signed(st[S].q);
    end else begin
      t_next = (st[S].q > 32'h8000_0000) ? rbsi_pkg::TMin : $signed(32'(-st[S].q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[S];
    end
    if (en) begin
      t   <= t_next;
      nan <= nan_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rbsi_slab.sv
// Slab ordering, overlap test, entry time and face normal.
`default_nettype none
module rbsi_slab (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic signed [31:0]    t_nx,
  input  wire logic signed [31:0]    t_ny,
  input  wire logic signed [31:0]    t_fx,
  input  wire logic signed [31:0]    t_fy,
  input  wire logic                  any_nan,
  input  wire rbsi_pkg::side_t       side,
  output logic                       out_vld,
  output rbsi_pkg::slab_t            res
);

  logic signed [31:0] nx, fx, ny, fy, tn, tf;
  rbsi_pkg::slab_t    res_next;

  always_comb begin
    nx = (t_nx > t_fx) ? t_fx : t_nx;
    fx = (t_nx > t_fx) ? t_nx : t_fx;
    ny = (t_ny > t_fy) ? t_fy : t_ny;
    fy = (t_ny > t_fy) ? t_ny : t_fy;
    tn = (nx > ny) ? nx : ny;
    tf = (fx < fy) ? fx : fy;
    res_next.side = side;
    res_next.hit  = !any_nan && !(nx > fy) && !(ny > fx) && !tf[31];
    res_next.tn   = tn;
    res_next.nx   = rbsi_pkg::NormZero;
    res_next.ny   = rbsi_pkg::NormZero;
    if (nx > ny) begin
      res_next.nx = side.dx[31] ? rbsi_pkg::NormPos : rbsi_pkg::NormNeg;
    end else if (nx < ny) begin
      res_next.ny = side.dy[31] ? rbsi_pkg::NormPos : rbsi_pkg::NormNeg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rbsi_contact.sv
// Contact point: product stage, then floor shift, add, saturate and output register.
`default_nettype none
module rbsi_contact (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire rbsi_pkg::slab_t   res,
  output logic                   out_vld,
  output logic [103:0]           data
);

  logic               m_vld;
  logic signed [63:0] px, py;
  rbsi_pkg::slab_t    m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= in_vld;
    end
    if (en) begin
      px    <= 64'(res.side.dx) * 64'(res.tn);
      py    <= 64'(res.side.dy) * 64'(res.tn);
      m_res <= res;
    end
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] o,
                                                 input logic signed [63:0] p);
    logic signed [48:0] s;
    begin
      s = 49'(o) + 49'(p >>> 16);
      if (s > 49'(rbsi_pkg::TMax)) sat_add = rbsi_pkg::TMax;
      else if (s < 49'(rbsi_pkg::TMin)) sat_add = rbsi_pkg::TMin;
      else sat_add = s[31:0];
    end
  endfunction

  logic [103:0] data_next;
  logic signed [31:0] cx, cy;

  always_comb begin
    cx = sat_add(m_res.side.ox, px);
    cy = sat_add(m_res.side.oy, py);
    data_next = '0;
    if (m_res.hit) begin
      data_next = {3'd0, m_res.ny, m_res.nx, cy, cx, m_res.tn, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= m_vld;
    end
    if (en) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

### rtl/ray_box_slab_intersect_2d.sv
// Stages from request acceptance to result: prep, 34-stage divider, slab, 2 contact.
// One request per cycle when not stalled; four parallel dividers, one quotient bit per stage.
// The whole pipeline advances together while the output register is empty or being taken.
// Reset (rst, synchronous, active high) clears all valid bits; payload registers keep data.
// Reset needs no clearing pass; requests are taken in the first cycle after reset.
`default_nettype none
module ray_box_slab_intersect_2d (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // origin_x[31:0] origin_y[63:32] dir_x[95:64] dir_y[127:96]
  // box_x[159:128] box_y[191:160] box_w[222:192] box_h[253:223], zero pad
  input  wire logic [255:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit[0] entry_time[32:1] contact_x[64:33] contact_y[96:65]
  // normal_x[98:97] normal_y[100:99], zero pad
  output logic [103:0]      m_tdata
);

  localparam int Lat = rbsi_pkg::DivLat;

  // Global advance: output register free or being drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  // No request is taken while reset holds the valid bits low.
  assign s_tready = en && !rst;

  // Unpack request fields.
  logic signed [31:0] ox, oy, dx, dy, bx, by;
  logic [30:0]        bw, bh;
  assign ox = s_tdata[31:0];
  assign oy = s_tdata[63:32];
  assign dx = s_tdata[95:64];
  assign dy = s_tdata[127:96];
  assign bx = s_tdata[159:128];
  assign by = s_tdata[191:160];
  assign bw = s_tdata[222:192];
  assign bh = s_tdata[253:223];

  // Prep stage: exact face numerators (34 bit signed).
  logic                     p_vld;
  logic signed [33:0]       n_nx, n_ny, n_fx, n_fy;
  rbsi_pkg::side_t          p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= s_tvalid;
    end
    if (en) begin
      n_nx   <= 34'(bx) - 34'(ox);
      n_ny   <= 34'(by) - 34'(oy);
      n_fx   <= 34'(bx) + 34'({1'b0, bw}) - 34'(ox);
      n_fy   <= 34'(by) + 34'({1'b0, bh}) - 34'(oy);
      p_side <= '{ox: ox, oy: oy, dx: dx, dy: dy};
    end
  end

  // Four face-time dividers.
  logic               v_nx, v_ny, v_fx, v_fy;
  logic signed [31:0] t_nx, t_ny, t_fx, t_fy;
  logic               z_nx, z_ny, z_fx, z_fy;

  rbsi_div u_div_nx (.clk, .rst, .en, .in_vld(p_vld), .num(n_nx), .dir(p_side.dx),
                     .out_vld(v_nx), .t(t_nx), .nan(z_nx));
  rbsi_div u_div_ny (.clk, .rst, .en, .in_vld(p_vld), .num(n_ny), .dir(p_side.dy),
                     .out_vld(v_ny), .t(t_ny), .nan(z_ny));
  rbsi_div u_div_fx (.clk, .rst, .en, .in_vld(p_vld), .num(n_fx), .dir(p_side.dx),
                     .out_vld(v_fx), .t(t_fx), .nan(z_fx));
  rbsi_div u_div_fy (.clk, .rst, .en, .in_vld(p_vld), .num(n_fy), .dir(p_side.dy),
                     .out_vld(v_fy), .t(t_fy), .nan(z_fy));

  // Ray data delay line matching the divider latency.
  rbsi_pkg::side_t side_d [0:Lat-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= p_side;
      for (int k = 1; k < Lat; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  logic            d_vld;
  assign d_vld = v_nx & v_ny & v_fx & v_fy;

  logic            s_vld;
  rbsi_pkg::slab_t s_res;

  rbsi_slab u_slab (
    .clk, .rst, .en,
    .in_vld  (d_vld),
    .t_nx, .t_ny, .t_fx, .t_fy,
    .any_nan (z_nx | z_ny | z_fx | z_fy),
    .side    (side_d[Lat-1]),
    .out_vld (s_vld),
    .res     (s_res)
  );

  rbsi_contact u_contact (
    .clk, .rst, .en,
    .in_vld  (s_vld),
    .res     (s_res),
    .out_vld (m_tvalid),
    .data    (m_tdata)
  );

endmodule
`default_nettype wire

### tb/sv/tb_ray_box_slab_intersect_2d.sv
// Regression bench for the 2D ray versus box slab test: directed and random requests.
`default_nettype none
module tb_ray_box_slab_intersect_2d;

  typedef struct {
    logic signed [31:0] ox, oy, dx, dy, bx, by;
    logic [30:0]        bw, bh;
  } ray_box_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] tn, cx, cy;
    logic signed [1:0]  nx, ny;
  } slab_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  slab_res_t hits_pending[$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;

  ray_box_slab_intersect_2d uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Face crossing time in Q16.16; returns 0 for the undefined 0/0 case.
  function automatic bit cross_time(longint num, longint dir, output longint t);
    t = 0;
    if (dir == 0) begin
      if (num == 0) return 1'b0;
      t = (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
      return 1'b1;
    end
    t = clamp32((num * 65536) / dir);
    return 1'b1;
  endfunction

  // origin + floor(dir * t / 2^16), saturated
  function automatic longint contact_at(longint org, longint dir, longint t);
    longint p;
    p = dir * t;
    return clamp32(org + (p >>> 16));
  endfunction

  function automatic slab_res_t slab_predict(ray_box_t r);
    slab_res_t res;
    longint ox, oy, dx, dy, nx, ny, fx, fy, tmp, tn, tf;
    res = '{default: '0};
    ox = r.ox; oy = r.oy; dx = r.dx; dy = r.dy;
    if (!cross_time(longint'(r.bx) - ox, dx, nx)) return res;
    if (!cross_time(longint'(r.by) - oy, dy, ny)) return res;
    if (!cross_time(longint'(r.bx) + longint'(r.bw) - ox, dx, fx)) return res;
    if (!cross_time(longint'(r.by) + longint'(r.bh) - oy, dy, fy)) return res;
    if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
    if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
    if (nx > fy || ny > fx) return res;
    tn = (nx > ny) ? nx : ny;
    tf = (fx < fy) ? fx : fy;
    if (tf < 0) return res;
    res.nx = rbsi_pkg::NormZero;
    res.ny = rbsi_pkg::NormZero;
    if (nx > ny) res.nx = (dx < 0) ? rbsi_pkg::NormPos : rbsi_pkg::NormNeg;
    else if (nx < ny) res.ny = (dy < 0) ? rbsi_pkg::NormPos : rbsi_pkg::NormNeg;
    res.hit = 1'b1;
    res.tn  = tn[31:0];
    res.cx  = 32'(contact_at(ox, dx, tn));
    res.cy  = 32'(contact_at(oy, dy, tn));
    return res;
  endfunction

  // Random idle on the request side; drops tvalid only when a gap is taken.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Send one request and log its expected result.
  task automatic send_ray(ray_box_t r);
    slab_res_t exp_r;
    s_tdata  <= {2'b00, r.bh, r.bw, r.by, r.bx, r.dy, r.dx, r.oy, r.ox};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_r = slab_predict(r);
    hits_pending = {hits_pending, exp_r};
    @(negedge clk);
  endtask

  task automatic send_gapped(ray_box_t r);
    idle_gap();
    send_ray(r);
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_box_t mk(int ox, int oy, int dx, int dy, int bx, int by,
                                  int bw, int bh);
    ray_box_t r;
    r.ox = ox; r.oy = oy; r.dx = dx; r.dy = dy;
    r.bx = bx; r.by = by; r.bw = bw[30:0]; r.bh = bh[30:0];
    return r;
  endfunction

  // Directed: hits on each face, misses, corner tie, zero direction, 0/0, extremes.
  task automatic test_directed();
    send_ray(mk(0, 32'h8000, 32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000));
    send_ray(mk(32'h30000, 32'h8000, -32'h10000, 0, 32'h10000, 0, 32'h10000,
                32'h10000));
    send_ray(mk(32'h8000, 0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 32'h10000));
    send_ray(mk(32'h8000, 32'h30000, 0, -32'h10000, 0, 32'h10000, 32'h10000,
                32'h10000));
    send_ray(mk(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                32'h10000));
    send_ray(mk(0, 0, -32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000));
    send_ray(mk(0, 32'h50000, 32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000));
    send_ray(mk(32'h10000, 32'h8000, 0, 32'h10000, 32'h10000, 0, 32'h10000,
                32'h10000));
    send_ray(mk(32'h8000, 32'h8000, 32'h10000, 32'h10000, 0, 0, 32'h10000,
                32'h10000));
    send_ray(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_ray(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk(32'h8000_0000, 32'h8000_0000, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk(0, 0, 1, -1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF));
    send_ray(mk(-1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, -2, 3, 5));
  endtask

  // Random: mostly boxes near the ray so hits are common, some raw noise.
  task automatic test_random(int count);
    ray_box_t r;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        r = mk(any_word(), any_word(), any_word(), any_word(), any_word(), any_word(),
               any_word(), any_word());
      end else begin
        r.ox = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        r.oy = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        r.dx = ($urandom_range(0, 7) == 0) ? 0 :
               $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        r.dy = ($urandom_range(0, 7) == 0) ? 0 :
               $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        r.bx = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        r.by = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        r.bw = 31'($urandom_range(0, 32'h3FFFF));
        r.bh = 31'($urandom_range(0, 32'h3FFFF));
      end
      send_gapped(r);
    end
  endtask

  // Sink stall pattern, with runs of no stalling.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if ($urandom_range(0, 15) == 0) m_tready <= 1'b1;
    else if ($urandom_range(0, 9) == 0) m_tready <= 1'b0;
    else if (!m_tready) m_tready <= ($urandom_range(0, 2) == 0);
  end

  // Result checker: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    slab_res_t exp_r;
    slab_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tdata[0];
      got.tn  = m_tdata[32:1];
      got.cx  = m_tdata[64:33];
      got.cy  = m_tdata[96:65];
      got.nx  = m_tdata[98:97];
      got.ny  = m_tdata[100:99];
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        exp_r = hits_pending.pop_front();
        if (got.hit !== exp_r.hit || got.tn !== exp_r.tn || got.cx !== exp_r.cx ||
            got.cy !== exp_r.cy || got.nx !== exp_r.nx || got.ny !== exp_r.ny) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d t=%h c=%h,%h n=%0d,%0d got hit=%0d t=%h c=%h,%h n=%0d,%0d",
                     exp_r.hit, exp_r.tn, exp_r.cx, exp_r.cy, exp_r.nx, exp_r.ny,
                     got.hit, got.tn, got.cx, got.cy, got.nx, got.ny);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800);
    s_tvalid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && hits_pending.size() == 0)
      $display("ray_box_slab_intersect_2d regression: pass");
    else
      $display("ray_box_slab_intersect_2d regression: fail");
    $finish;
  end

  initial begin
    #12000000;
    $display("ray_box_slab_intersect_2d regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
